FILE: src/lrukv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrukv_pkg: shared definitions for the LRU key-value cache
// Default sizes, the configuration field width and the request operation codes.
// ----------------------------------------------------------------------------
package lrukv_pkg;

  // Default geometry of the store.
  localparam int unsigned EntriesDef   = 16;
  localparam int unsigned KeyBitsDef   = 16;
  localparam int unsigned ValueBitsDef = 32;

  // Width of the capacity field on the configuration port.
  localparam int unsigned CapCfgBits = 5;

  // Highest capacity that reset selects.
  localparam int unsigned CapResetMax = 16;

  // Request operation carried on the slave-side tuser.
  typedef enum logic [0:0] {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_e;

endpackage

FILE: src/lru_key_value_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key-value store with LRU replacement
// Get and put requests against up to ENTRIES entries, one request per cycle when unstalled.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_axis channel. tuser carries the operation (get or
//   put), tdata carries the key in the low bits and the value above it. Each
//   request produces exactly one response on the m_axis channel: tuser is the
//   hit flag (the key was present before the request) and tdata is the stored
//   value on a get hit, zero otherwise.
//   A request is captured in an input register, the key compare, LRU rank
//   update and replacement choice run combinationally on it, and the response
//   lands in an output register. Throughput is one request per cycle while
//   the receiver keeps up; lookup and rank update over all entries are combinational.
//   When the receiver stalls, the output register holds its response and the
//   input register still takes one more request; further requests wait.
//   Reset empties the store (all entries invalid, no occupied slots) and sets
//   the capacity to the smaller of ENTRIES and sixteen. The capacity is
//   written through cfg_we_i/cfg_wdata_i; a write is ignored unless the store
//   is empty, zero is stored as one, and values above ENTRIES as ENTRIES.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
  parameter int unsigned ENTRIES    = lrukv_pkg::EntriesDef,
  parameter int unsigned KEY_BITS   = lrukv_pkg::KeyBitsDef,
  parameter int unsigned VALUE_BITS = lrukv_pkg::ValueBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,

  // Configuration: capacity register.
  input  logic                             cfg_we_i,
  input  logic [lrukv_pkg::CapCfgBits-1:0] cfg_wdata_i,

  // Request channel.
  input  logic                                              s_axis_tvalid,
  output logic                                              s_axis_tready,
  // tdata, low bits first: key, value, zero padding to whole bytes.
  input  logic [((KEY_BITS + VALUE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // tuser: operation (0 = get, 1 = put).
  input  logic                                              s_axis_tuser,

  // Response channel.
  output logic                                      m_axis_tvalid,
  input  logic                                      m_axis_tready,
  // tdata, low bits first: read_value, zero padding to whole bytes.
  output logic [((VALUE_BITS + 7) / 8) * 8 - 1:0]   m_axis_tdata,
  // tuser: hit.
  output logic                                      m_axis_tuser
);

  localparam int unsigned OutTdataW = ((VALUE_BITS + 7) / 8) * 8;
  // Rank of an entry: 0 is the most recent, occupied - 1 the least recent.
  localparam int unsigned AgeW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  // Counts from 0 up to ENTRIES.
  localparam int unsigned CntW      = $clog2(ENTRIES + 1);
  localparam int unsigned CapRst    =
      (ENTRIES < lrukv_pkg::CapResetMax) ? ENTRIES : lrukv_pkg::CapResetMax;

  // Input register.
  logic                  in_valid_q;
  lrukv_pkg::op_e        in_op_q;
  logic [KEY_BITS-1:0]   in_key_q;
  logic [VALUE_BITS-1:0] in_value_q;

  // Output register.
  logic                  out_valid_q;
  logic                  out_hit_q;
  logic [VALUE_BITS-1:0] out_value_q;

  // Store.
  logic [ENTRIES-1:0]    valid_q, valid_d;
  logic [KEY_BITS-1:0]   key_q   [ENTRIES];
  logic [VALUE_BITS-1:0] value_q [ENTRIES];
  logic [AgeW-1:0]       age_q   [ENTRIES];
  logic [AgeW-1:0]       age_d   [ENTRIES];
  logic [CntW-1:0]       occ_q, occ_d;
  logic [CntW-1:0]       cap_q;

  // Lookup and replacement.
  logic                  advance;
  logic [ENTRIES-1:0]    match;
  logic [ENTRIES-1:0]    free_oh;
  logic [ENTRIES-1:0]    victim;
  logic [ENTRIES-1:0]    sel;
  logic                  hit;
  logic [AgeW-1:0]       hit_age;
  logic [VALUE_BITS-1:0] hit_value;
  logic                  has_room;
  logic                  is_put;
  logic                  do_insert;
  logic                  do_evict;
  logic [CntW-1:0]       old_rank;
  logic [CntW-1:0]       cap_wr;

  // The input register moves on when the output register is empty or drains.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_op_q    <= lrukv_pkg::op_e'(s_axis_tuser);
      in_key_q   <= s_axis_tdata[KEY_BITS-1:0];
      in_value_q <= s_axis_tdata[KEY_BITS +: VALUE_BITS];
    end
  end

  // Keys are unique among valid entries, so at most one entry matches and the
  // victim (rank occupied - 1) and the lowest free slot are single entries too.
  always_comb begin
    match     = '0;
    victim    = '0;
    hit_age   = '0;
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]  = valid_q[i] && (key_q[i] == in_key_q);
      victim[i] = valid_q[i] && (CntW'(age_q[i]) == occ_q - 1'b1);
      hit_age   = hit_age   | (age_q[i]   & {AgeW{match[i]}});
      hit_value = hit_value | (value_q[i] & {VALUE_BITS{match[i]}});
    end
    hit       = |match;
    free_oh   = ~valid_q & (valid_q + 1'b1);
    has_room  = occ_q < cap_q;
    is_put    = (in_op_q == lrukv_pkg::OP_PUT);
    do_insert = is_put && !hit && has_room;
    do_evict  = is_put && !hit && !has_room;

    priority if (hit) begin
      sel      = match;
      old_rank = CntW'(hit_age);
    end else if (do_insert) begin
      // The new entry ranks ahead of every valid one, so all of them age.
      sel      = free_oh;
      old_rank = occ_q;
    end else if (do_evict) begin
      sel      = victim;
      old_rank = occ_q - 1'b1;
    end else begin
      sel      = '0;
      old_rank = '0;
    end

    // Promote the selected entry; entries more recent than its old rank age.
    valid_d = valid_q;
    for (int i = 0; i < ENTRIES; i++) begin
      age_d[i] = age_q[i];
      if (advance) begin
        if (sel[i]) begin
          age_d[i] = '0;
        end else if ((|sel) && valid_q[i] && (CntW'(age_q[i]) < old_rank)) begin
          age_d[i] = age_q[i] + 1'b1;
        end
        if (do_insert && free_oh[i]) begin
          valid_d[i] = 1'b1;
        end
      end
    end

    occ_d = occ_q;
    if (advance && do_insert) begin
      occ_d = occ_q + 1'b1;
    end

    // Clamp the requested capacity into 1..ENTRIES.
    if (cfg_wdata_i == '0) begin
      cap_wr = CntW'(1);
    end else if (32'(cfg_wdata_i) > ENTRIES) begin
      cap_wr = CntW'(ENTRIES);
    end else begin
      cap_wr = CntW'(cfg_wdata_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
      cap_q   <= CntW'(CapRst);
      for (int i = 0; i < ENTRIES; i++) begin
        age_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      occ_q   <= occ_d;
      age_q   <= age_d;
      if (cfg_we_i && (occ_q == '0)) begin
        cap_q <= cap_wr;
      end
    end
  end

  // Key and value slots are only read through a set valid bit.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (advance && sel[i] && is_put) begin
        value_q[i] <= in_value_q;
        if (!hit) begin
          key_q[i] <= in_key_q;
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_hit_q   <= hit;
      out_value_q <= (hit && !is_put) ? hit_value : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_hit_q;
  assign m_axis_tdata  = OutTdataW'(out_value_q);

`ifndef NO_ASSERTIONS
  // The number of valid entries always equals the occupancy count.
  a_occ_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(occ_q))
    else $error("occupancy count differs from number of valid entries");

  // The store never holds more entries than the configured capacity.
  a_occ_le_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= cap_q)
    else $error("occupancy exceeds capacity");

  // A key is held by at most one valid entry.
  a_unique_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q |-> $onehot0(match))
    else $error("key matches more than one entry");

  // A full store under a put miss always finds exactly one victim.
  a_one_victim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && do_evict) |-> $onehot(victim))
    else $error("eviction without a unique least recent entry");
`endif

endmodule
